### design/slha_pkg.sv
// ----------------------------------------------------------------------------
// slha_pkg: shared types and constants for the smoke level alarm
// Command codes, register indexes, coefficients and the sequencer states.
// ----------------------------------------------------------------------------
package slha_pkg;

    // Fixed widths of the configuration port and of the result level.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 26;
    localparam int CONC_W     = 26;
    localparam int THR_W      = 26;
    localparam int FACTOR_W   = 16;
    localparam int COUNT_W    = 16;

    // EMA coefficients in Q0.16: alpha = 0.2 and one minus alpha.
    localparam int COEF_W = 16;
    localparam logic [COEF_W-1:0] ALPHA_Q16           = 16'd13107;
    localparam logic [COEF_W-1:0] ONE_MINUS_ALPHA_Q16 = 16'd52429;

    // Register reset values.
    localparam logic [FACTOR_W-1:0] SCALE_RESET  = 16'd1966;
    localparam logic [THR_W-1:0]    THRESH_RESET = 26'd12800;
    localparam logic [THR_W-1:0]    BAND_RESET   = 26'd1280;
    localparam logic [COUNT_W-1:0]  CALIB_RESET  = 16'd64;

    // Command codes.
    localparam logic [1:0] CMD_MEASURE  = 2'd0;
    localparam logic [1:0] CMD_CALIB    = 2'd1;
    localparam logic [1:0] CMD_READ_CLR = 2'd2;
    localparam logic [1:0] CMD_CLEAR    = 2'd3;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BAND   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CALIB  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EMA_X,
        ST_EMA_F,
        ST_EMA_SUM,
        ST_DIFF,
        ST_SCALE,
        ST_ROUND,
        ST_COMPARE,
        ST_CAL_ADD,
        ST_CAL_CHECK,
        ST_CAL_DIV,
        ST_FINISH
    } state_t;

endpackage

### design/slha_divider.sv
// ----------------------------------------------------------------------------
// slha_divider: restoring unsigned divider
// Produces one quotient bit per cycle; done pulses when the quotient is ready.
// ----------------------------------------------------------------------------
module slha_divider #(
    parameter int DIVIDEND_W = 43,
    parameter int DIVISOR_W  = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    trial_diff;

    always_comb
    begin
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dsr_next   = dsr_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        trial      = {rem_reg, quo_reg[DIVIDEND_W-1]};
        trial_diff = trial - {1'b0, dsr_reg};

        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = CNT_W'(DIVIDEND_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // Shift the next dividend bit into the remainder and try a subtract.
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = trial_diff[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### design/smoke_level_hysteresis_alarm.sv
// ----------------------------------------------------------------------------
// smoke_level_hysteresis_alarm: filtered smoke level with hysteresis alarm
// EMA filter, baseline calibration, scaling and alarm comparator, built
// around one shared multiplier and a serial divider under a sequencer.
// ----------------------------------------------------------------------------
// Steps from input transfer to result valid: a measure runs EMA_X, EMA_F,
// EMA_SUM, DIFF, SCALE, ROUND and COMPARE; a calibration sample CAL_ADD and
// CAL_CHECK; calibration completion also CAL_DIV, set by the bit-serial divider;
// a trigger read or clear goes straight to FINISH. One item at a time; the next
// item is accepted the cycle after the result is loaded into the output register.
// Reset is asynchronous: state and flags clear, registers take their defaults.
module smoke_level_hysteresis_alarm
    import slha_pkg::*;
#(
    parameter int SAMPLE_BITS = 18,
    parameter int FRAC_BITS   = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [1:0]             cmd,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                   sample_valid,

    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [CONC_W-1:0]      concentration,
    output logic                   alarm_active,
    output logic                   trigger_seen,
    output logic                   calibration_done,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int LEVEL_BITS = SAMPLE_BITS + FRAC_BITS;
    localparam int SUM_W      = SAMPLE_BITS + 16;
    localparam int PROD_W     = LEVEL_BITS + COEF_W;
    localparam int ACC_W      = PROD_W + 1;
    localparam int DIV_W      = SUM_W + FRAC_BITS + 1;
    localparam int CMP_W      = ((LEVEL_BITS > THR_W) ? LEVEL_BITS : THR_W) + 1;
    localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEF_W - 1);
    localparam logic [LEVEL_BITS:0] FRAC_HALF = (LEVEL_BITS + 1)'(1) << (FRAC_BITS - 1);

    state_t state_reg, state_next;

    // Configuration registers.
    logic [FACTOR_W-1:0] scale_reg, scale_next;
    logic [THR_W-1:0]    thr_reg, thr_next;
    logic [THR_W-1:0]    band_reg, band_next;
    logic [COUNT_W-1:0]  calib_n_reg, calib_n_next;

    // Persistent state.
    logic [LEVEL_BITS-1:0] filt_reg, filt_next;
    logic [LEVEL_BITS-1:0] base_reg, base_next;
    logic                  alarm_reg, alarm_next;
    logic                  latch_reg, latch_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [COUNT_W-1:0]    count_reg, count_next;

    // Working registers.
    logic                  sval_reg, sval_next;
    logic [LEVEL_BITS-1:0] x_reg, x_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic [ACC_W-1:0]      acc_reg, acc_next;
    logic [LEVEL_BITS-1:0] conc_reg, conc_next;
    logic                  seen_reg, seen_next;
    logic                  cdone_reg, cdone_next;

    // Output register.
    logic                  ov_reg, ov_next;
    logic [CONC_W-1:0]     oconc_reg, oconc_next;
    logic                  oalarm_reg, oalarm_next;
    logic                  oseen_reg, oseen_next;
    logic                  odone_reg, odone_next;

    // Shared multiplier and scratch values.
    logic [LEVEL_BITS-1:0] mul_a;
    logic [COEF_W-1:0]     mul_b;
    logic [PROD_W-1:0]     mul_p;
    logic [ACC_W-1:0]      ema_sum;
    logic [ACC_W-1:0]      scaled;
    logic [LEVEL_BITS:0]   filt_round;
    logic [SAMPLE_BITS:0]  filt_int;
    logic [SAMPLE_BITS-1:0] cal_sample;
    logic [COUNT_W-1:0]    need;
    logic [CMP_W-1:0]      conc_c, thr_c, band_c;

    logic                  div_start;
    logic [DIV_W-1:0]      div_dividend;
    logic                  div_done;
    logic [DIV_W-1:0]      div_quotient;

    logic                  in_xfer;
    logic                  out_free;

    assign mul_p    = mul_a * mul_b;
    assign in_xfer  = in_valid && (state_reg == ST_IDLE);
    assign out_free = !ov_reg || !out_stall;

    slha_divider #(
        .DIVIDEND_W (DIV_W),
        .DIVISOR_W  (COUNT_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin
        state_next   = state_reg;
        scale_next   = scale_reg;
        thr_next     = thr_reg;
        band_next    = band_reg;
        calib_n_next = calib_n_reg;
        filt_next    = filt_reg;
        base_next    = base_reg;
        alarm_next   = alarm_reg;
        latch_next   = latch_reg;
        sum_next     = sum_reg;
        count_next   = count_reg;
        sval_next    = sval_reg;
        x_next       = x_reg;
        prod_next    = prod_reg;
        acc_next     = acc_reg;
        conc_next    = conc_reg;
        seen_next    = seen_reg;
        cdone_next   = cdone_reg;
        ov_next      = ov_reg;
        oconc_next   = oconc_reg;
        oalarm_next  = oalarm_reg;
        oseen_next   = oseen_reg;
        odone_next   = odone_reg;
        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;
        div_dividend = DIV_W'({sum_reg, {FRAC_BITS{1'b0}}}) + DIV_W'(count_reg >> 1);
        ema_sum      = acc_reg + ACC_W'(prod_reg);
        scaled       = ACC_W'(prod_reg) + ROUND_HALF;
        filt_round   = (LEVEL_BITS + 1)'(filt_reg) + FRAC_HALF;
        filt_int     = filt_round[FRAC_BITS +: SAMPLE_BITS + 1];
        need         = (calib_n_reg == '0) ? COUNT_W'(1) : calib_n_reg;
        conc_c       = CMP_W'(conc_reg);
        thr_c        = CMP_W'(thr_reg);
        band_c       = CMP_W'(band_reg);

        // A timed-out reading during calibration uses the rounded filter value.
        if (sval_reg)
        begin
            cal_sample = x_reg[FRAC_BITS +: SAMPLE_BITS];
        end
        else if (filt_int[SAMPLE_BITS])
        begin
            cal_sample = '1;
        end
        else
        begin
            cal_sample = filt_int[SAMPLE_BITS-1:0];
        end

        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end

        if (cfg_valid)
        begin
            case (cfg_index)
                REG_SCALE:  scale_next   = cfg_data[FACTOR_W-1:0];
                REG_THRESH: thr_next     = cfg_data[THR_W-1:0];
                REG_BAND:   band_next    = cfg_data[THR_W-1:0];
                REG_CALIB:  calib_n_next = cfg_data[COUNT_W-1:0];
                default:    ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    sval_next = sample_valid;
                    x_next    = sample_valid ? {sample, {FRAC_BITS{1'b0}}} : filt_reg;
                    case (cmd)
                        CMD_MEASURE: state_next = ST_EMA_X;
                        CMD_CALIB:   state_next = ST_CAL_ADD;
                        default:
                        begin
                            seen_next  = latch_reg;
                            latch_next = 1'b0;
                            conc_next  = '0;
                            cdone_next = 1'b0;
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_EMA_X:
            begin
                mul_a      = x_reg;
                mul_b      = ALPHA_Q16;
                prod_next  = mul_p;
                state_next = ST_EMA_F;
            end
            ST_EMA_F:
            begin
                acc_next   = ACC_W'(prod_reg) + ROUND_HALF;
                mul_a      = filt_reg;
                mul_b      = ONE_MINUS_ALPHA_Q16;
                prod_next  = mul_p;
                state_next = ST_EMA_SUM;
            end
            ST_EMA_SUM:
            begin
                filt_next  = ema_sum[COEF_W +: LEVEL_BITS];
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                x_next     = (filt_reg > base_reg) ? filt_reg - base_reg : '0;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                mul_a      = x_reg;
                mul_b      = scale_reg;
                prod_next  = mul_p;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                conc_next  = scaled[COEF_W +: LEVEL_BITS];
                state_next = ST_COMPARE;
            end
            ST_COMPARE:
            begin
                // Release only once the level sits a full band below threshold.
                seen_next = latch_reg;
                if (!alarm_reg && (conc_c > thr_c))
                begin
                    alarm_next = 1'b1;
                    latch_next = 1'b1;
                    seen_next  = 1'b1;
                end
                else if (alarm_reg && (conc_c + band_c <= thr_c))
                begin
                    alarm_next = 1'b0;
                end
                cdone_next = 1'b0;
                state_next = ST_FINISH;
            end
            ST_CAL_ADD:
            begin
                sum_next   = sum_reg + SUM_W'(cal_sample);
                count_next = (count_reg == '1) ? count_reg : count_reg + COUNT_W'(1);
                state_next = ST_CAL_CHECK;
            end
            ST_CAL_CHECK:
            begin
                if (count_reg >= need)
                begin
                    div_start  = 1'b1;
                    state_next = ST_CAL_DIV;
                end
                else
                begin
                    seen_next  = latch_reg;
                    conc_next  = '0;
                    cdone_next = 1'b0;
                    state_next = ST_FINISH;
                end
            end
            ST_CAL_DIV:
            begin
                if (div_done)
                begin
                    base_next  = div_quotient[LEVEL_BITS-1:0];
                    filt_next  = div_quotient[LEVEL_BITS-1:0];
                    sum_next   = '0;
                    count_next = '0;
                    seen_next  = latch_reg;
                    conc_next  = '0;
                    cdone_next = 1'b1;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    ov_next     = 1'b1;
                    oconc_next  = CONC_W'(conc_reg);
                    oalarm_next = alarm_reg;
                    oseen_next  = seen_reg;
                    odone_next  = cdone_reg;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            scale_reg   <= SCALE_RESET;
            thr_reg     <= THRESH_RESET;
            band_reg    <= BAND_RESET;
            calib_n_reg <= CALIB_RESET;
            filt_reg    <= '0;
            base_reg    <= '0;
            alarm_reg   <= 1'b0;
            latch_reg   <= 1'b0;
            sum_reg     <= '0;
            count_reg   <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            scale_reg   <= scale_next;
            thr_reg     <= thr_next;
            band_reg    <= band_next;
            calib_n_reg <= calib_n_next;
            filt_reg    <= filt_next;
            base_reg    <= base_next;
            alarm_reg   <= alarm_next;
            latch_reg   <= latch_next;
            sum_reg     <= sum_next;
            count_reg   <= count_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sval_reg   <= sval_next;
        x_reg      <= x_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        conc_reg   <= conc_next;
        seen_reg   <= seen_next;
        cdone_reg  <= cdone_next;
        oconc_reg  <= oconc_next;
        oalarm_reg <= oalarm_next;
        oseen_reg  <= oseen_next;
        odone_reg  <= odone_next;
    end

    assign in_stall         = (state_reg != ST_IDLE);
    assign cfg_ready        = 1'b1;
    assign out_valid        = ov_reg;
    assign concentration    = oconc_reg;
    assign alarm_active     = oalarm_reg;
    assign trigger_seen     = oseen_reg;
    assign calibration_done = odone_reg;

endmodule

### design/slha_checker.sv
// ----------------------------------------------------------------------------
// slha_checker: port-level assertions for the smoke level alarm
// Watches the handshakes and result fields; bound to the top level below.
// ----------------------------------------------------------------------------
module slha_checker
    import slha_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic [CONC_W-1:0] concentration,
    input logic              alarm_active,
    input logic              trigger_seen,
    input logic              calibration_done
);

    logic last_alarm_reg;

    // Alarm state as shown by the last result transferred.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_alarm_reg <= 1'b0;
        end
        else if (out_valid && !out_stall)
        begin
            last_alarm_reg <= alarm_active;
        end
    end

    // Every accepted item keeps the block busy in the cycle after its transfer.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted again right after a transfer");

    // A finished calibration never reports a concentration.
    a_calib_no_conc: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && calibration_done) |-> (concentration == '0))
        else $error("calibration result carries a concentration");

    // A rising alarm always comes with the sticky trigger set.
    a_rise_sets_trigger: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && alarm_active && !last_alarm_reg) |-> trigger_seen)
        else $error("alarm rose without the trigger flag");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(concentration)
            && $stable(alarm_active) && $stable(trigger_seen)
            && $stable(calibration_done)))
        else $error("stalled result changed");

endmodule

bind smoke_level_hysteresis_alarm slha_checker u_slha_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .concentration    (concentration),
    .alarm_active     (alarm_active),
    .trigger_seen     (trigger_seen),
    .calibration_done (calibration_done)
);

### tb/slha_alarm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slha_alarm_checker: result predictor and scoreboard for the smoke alarm
// Watches the input, result and register channels, predicts each result from
// its own copy of the filter, baseline, alarm and calibration state, and
// compares every result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module slha_alarm_checker
    import slha_pkg::*;
#(
    parameter int SAMPLE_BITS = 18,
    parameter int FRAC_BITS   = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic [1:0]             cmd,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                   sample_valid,

    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic [CONC_W-1:0]      concentration,
    input  logic                   alarm_active,
    input  logic                   trigger_seen,
    input  logic                   calibration_done,

    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    output int                     errors,
    output int                     pending
);

    localparam int LEVEL_W = SAMPLE_BITS + FRAC_BITS;
    localparam int SUM_W   = SAMPLE_BITS + 16;
    localparam logic [63:0] SAMPLE_MAX = (64'd1 << SAMPLE_BITS) - 64'd1;

    typedef struct packed {
        logic [CONC_W-1:0] conc;
        logic              alarm;
        logic              seen;
        logic              done;
    } alarm_result_t;

    // Register copies.
    logic [FACTOR_W-1:0] scale_q;
    logic [THR_W-1:0]    thresh_q;
    logic [THR_W-1:0]    band_q;
    logic [COUNT_W-1:0]  calib_q;

    // Block state as the predictor sees it.
    logic [LEVEL_W-1:0]  filt_lvl;
    logic [LEVEL_W-1:0]  base_lvl;
    logic                alarm_q;
    logic                trig_q;
    logic [SUM_W-1:0]    cal_sum;
    logic [COUNT_W-1:0]  cal_cnt;

    alarm_result_t       expected_results[$];
    alarm_result_t       got;
    alarm_result_t       want;
    int                  mismatch_count = 0;

    function automatic alarm_result_t predict_alarm_result(
        input logic [1:0]             c,
        input logic [SAMPLE_BITS-1:0] smp,
        input logic                   sv
    );
        logic [63:0]   x;
        logic [63:0]   f_next;
        logic [63:0]   diff;
        logic [63:0]   conc;
        logic [63:0]   s;
        logic [63:0]   need;
        logic [63:0]   mean;
        alarm_result_t r;
        r      = '0;
        r.seen = trig_q;
        case (c)
            CMD_MEASURE:
            begin
                // A timed-out reading feeds the filter its own value.
                x = sv ? (64'(smp) << FRAC_BITS) : 64'(filt_lvl);
                f_next = (x * 64'(ALPHA_Q16) + 64'(filt_lvl) * 64'(ONE_MINUS_ALPHA_Q16)
                          + 64'd32768) >> 16;
                filt_lvl = f_next[LEVEL_W-1:0];
                diff = (filt_lvl > base_lvl) ? 64'(filt_lvl) - 64'(base_lvl) : 64'd0;
                conc = (diff * 64'(scale_q) + 64'd32768) >> 16;
                r.conc = conc[CONC_W-1:0];
                if (!alarm_q && 64'(r.conc) > 64'(thresh_q))
                begin
                    alarm_q = 1'b1;
                    trig_q  = 1'b1;
                end
                else if (alarm_q && 64'(r.conc) + 64'(band_q) <= 64'(thresh_q))
                begin
                    alarm_q = 1'b0;
                end
                r.seen = trig_q;
            end
            CMD_CALIB:
            begin
                need = (calib_q == '0) ? 64'd1 : 64'(calib_q);
                if (sv)
                begin
                    s = 64'(smp);
                end
                else
                begin
                    s = (64'(filt_lvl) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
                    if (s > SAMPLE_MAX)
                        s = SAMPLE_MAX;
                end
                cal_sum = SUM_W'(64'(cal_sum) + s);
                cal_cnt = cal_cnt + 1'b1;
                if (cal_cnt == '0)
                    cal_cnt = '1;
                if (64'(cal_cnt) >= need)
                begin
                    mean = ((64'(cal_sum) << FRAC_BITS) + 64'(cal_cnt >> 1)) / 64'(cal_cnt);
                    base_lvl = mean[LEVEL_W-1:0];
                    filt_lvl = base_lvl;
                    cal_sum  = '0;
                    cal_cnt  = '0;
                    r.done   = 1'b1;
                end
            end
            default:
            begin
                trig_q = 1'b0;
            end
        endcase
        r.alarm = alarm_q;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_q  = SCALE_RESET;
            thresh_q = THRESH_RESET;
            band_q   = BAND_RESET;
            calib_q  = CALIB_RESET;
            filt_lvl = '0;
            base_lvl = '0;
            alarm_q  = 1'b0;
            trig_q   = 1'b0;
            cal_sum  = '0;
            cal_cnt  = '0;
            expected_results.delete();
            pending <= 0;
            errors  <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SCALE:  scale_q  = cfg_data[FACTOR_W-1:0];
                    REG_THRESH: thresh_q = cfg_data[THR_W-1:0];
                    REG_BAND:   band_q   = cfg_data[THR_W-1:0];
                    REG_CALIB:  calib_q  = cfg_data[COUNT_W-1:0];
                    default:    ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                got = '{concentration, alarm_active, trigger_seen, calibration_done};
                if (expected_results.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("%0t: result transfer with nothing expected: conc %0d", $time,
                                 got.conc);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        if (mismatch_count < 10)
                            $display({"%0t: mismatch conc exp %0d got %0d, alarm exp %0b got %0b,",
                                      " seen exp %0b got %0b, done exp %0b got %0b"}, $time,
                                     want.conc, got.conc, want.alarm, got.alarm,
                                     want.seen, got.seen, want.done, got.done);
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_results.push_back(predict_alarm_result(cmd, sample, sample_valid));
            pending <= expected_results.size();
            errors  <= mismatch_count;
        end
    end

endmodule

### tb/smoke_level_hysteresis_alarm_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smoke_level_hysteresis_alarm_tb: stimulus and verdict for the smoke alarm
// A directed pass over the field extremes, every command and the calibration
// and hysteresis corner cases, then random phases under several register
// settings with random gaps on both channels. The checker scores results.
// ----------------------------------------------------------------------------
module smoke_level_hysteresis_alarm_tb;
    import slha_pkg::*;

    localparam int SAMPLE_BITS  = 18;
    localparam int FRAC_BITS    = 8;
    localparam int RUN_ITEMS    = 1500;
    localparam int PHASES       = 6;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int SAMPLE_TOP   = (1 << SAMPLE_BITS) - 1;
    localparam int THRESH_TOP   = (1 << THR_W) - 1;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   in_valid     = 1'b0;
    logic [1:0]             cmd          = CMD_MEASURE;
    logic [SAMPLE_BITS-1:0] sample       = '0;
    logic                   sample_valid = 1'b0;
    logic                   out_stall    = 1'b0;
    logic                   cfg_valid    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index    = REG_SCALE;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;

    logic                   in_stall;
    logic                   out_valid;
    logic [CONC_W-1:0]      concentration;
    logic                   alarm_active;
    logic                   trigger_seen;
    logic                   calibration_done;
    logic                   cfg_ready;

    int                     errors;
    int                     pending;
    int                     cycles   = 0;
    int                     level    = 0;
    logic                   quiet    = 1'b0;
    logic                   in_acc   = 1'b0;
    logic                   cfg_acc  = 1'b0;

    smoke_level_hysteresis_alarm #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .cmd              (cmd),
        .sample           (sample),
        .sample_valid     (sample_valid),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .concentration    (concentration),
        .alarm_active     (alarm_active),
        .trigger_seen     (trigger_seen),
        .calibration_done (calibration_done),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    slha_alarm_checker #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) alarm_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .cmd              (cmd),
        .sample           (sample),
        .sample_valid     (sample_valid),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .concentration    (concentration),
        .alarm_active     (alarm_active),
        .trigger_seen     (trigger_seen),
        .calibration_done (calibration_done),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .errors           (errors),
        .pending          (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Transfer flags are captured at the rising edge and read at the falling one.
    always @(posedge clk)
    begin
        in_acc  <= in_valid && !in_stall;
        cfg_acc <= cfg_valid && cfg_ready;
        cycles  <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(negedge clk)
        out_stall <= !quiet && ($urandom_range(99) < 7);

    task automatic push_item(input logic [1:0] c, input int s, input logic v);
        while (!quiet && $urandom_range(99) < 7)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        cmd          <= c;
        sample       <= SAMPLE_BITS'(s);
        sample_valid <= v;
        do
            @(negedge clk);
        while (!in_acc);
    endtask

    task automatic wait_idle;
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        do
            @(negedge clk);
        while (!cfg_acc);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic load_settings(input int unsigned sc, input int unsigned thr,
                                 input int unsigned band, input int unsigned cal);
        write_reg(REG_SCALE, sc);
        write_reg(REG_THRESH, thr);
        write_reg(REG_BAND, band);
        write_reg(REG_CALIB, cal);
    endtask

    // Thresholds are placed inside the reachable concentration range so that
    // the comparator toggles; a wide band, no narrower than the threshold, lets the alarm release only at zero level.
    task automatic load_random_settings(input logic wide_band);
        int unsigned sc;
        int unsigned thr;
        int unsigned band;
        sc   = $urandom_range(65535, 1);
        thr  = $urandom_range(int'((64'(THRESH_TOP) * sc) >> 17));
        band = wide_band ? $urandom_range(THRESH_TOP, thr) : $urandom_range(thr);
        load_settings(sc, thr, band, $urandom_range(8, 1));
    endtask

    // Readings follow a noisy level that jumps now and then, so the filter
    // drifts across the baseline and the alarm both sets and releases.
    task automatic push_random_item;
        int unsigned pick;
        int          s;
        logic [1:0]  c;
        pick = $urandom_range(99);
        if (pick < 72)
            c = CMD_MEASURE;
        else if (pick < 86)
            c = CMD_CALIB;
        else if (pick < 94)
            c = CMD_READ_CLR;
        else
            c = CMD_CLEAR;
        if ($urandom_range(99) < 10)
            level = $urandom_range(SAMPLE_TOP);
        if ($urandom_range(99) < 6)
        begin
            s = $urandom_range(SAMPLE_TOP);
        end
        else
        begin
            s = level + int'($urandom_range(2048)) - 1024;
            if (s < 0)
                s = 0;
            if (s > SAMPLE_TOP)
                s = SAMPLE_TOP;
        end
        push_item(c, s, $urandom_range(99) >= 10);
    endtask

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed pass: field extremes, every command, timed-out readings.
        write_reg(REG_CALIB, 2);
        push_item(CMD_MEASURE, 0, 1'b1);
        push_item(CMD_MEASURE, SAMPLE_TOP, 1'b1);
        push_item(CMD_MEASURE, 12345, 1'b0);
        push_item(CMD_READ_CLR, 0, 1'b1);
        push_item(CMD_READ_CLR, SAMPLE_TOP, 1'b0);
        push_item(CMD_CLEAR, 0, 1'b1);
        push_item(CMD_CALIB, SAMPLE_TOP, 1'b1);
        push_item(CMD_CALIB, 0, 1'b0);
        push_item(CMD_MEASURE, 0, 1'b1);
        push_item(CMD_CALIB, SAMPLE_TOP, 1'b1);
        push_item(CMD_CALIB, SAMPLE_TOP, 1'b1);
        push_item(CMD_MEASURE, SAMPLE_TOP, 1'b1);
        push_item(CMD_MEASURE, 0, 1'b0);

        // Sample count lowered in the middle of a calibration.
        wait_idle();
        write_reg(REG_CALIB, 65535);
        push_item(CMD_CALIB, 100, 1'b1);
        push_item(CMD_CALIB, 200, 1'b1);
        push_item(CMD_CALIB, SAMPLE_TOP, 1'b1);
        wait_idle();
        write_reg(REG_CALIB, 1);
        push_item(CMD_CALIB, 7, 1'b1);

        // A zero sample count behaves as one.
        wait_idle();
        write_reg(REG_CALIB, 0);
        push_item(CMD_CALIB, 5000, 1'b1);

        // A release band wider than the threshold latches the alarm on.
        wait_idle();
        write_reg(REG_THRESH, 100);
        write_reg(REG_BAND, 1000);
        push_item(CMD_MEASURE, SAMPLE_TOP, 1'b1);
        push_item(CMD_MEASURE, 0, 1'b1);
        push_item(CMD_CALIB, SAMPLE_TOP, 1'b1);
        push_item(CMD_MEASURE, 0, 1'b1);
        push_item(CMD_READ_CLR, 0, 1'b1);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            case (p)
                0: load_settings(32'(SCALE_RESET), 32'(THRESH_RESET), 32'(BAND_RESET),
                                 32'(CALIB_RESET));
                2: load_settings(65535, 0, 0, 1);
                3: load_settings(0, THRESH_TOP, THRESH_TOP, 2);
                4: load_random_settings(1'b1);
                default: load_random_settings(1'b0);
            endcase
            quiet = (p == 1);
            for (int i = 0; i < RUN_ITEMS / PHASES; i++)
                push_random_item();
        end
        quiet = 1'b0;

        wait_idle();
        repeat (60) @(negedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
